@@ sv/usbsx_pkg.sv @@
// Shared constants for the USB MIDI SysEx reassembler.
`default_nettype none

package usbsx_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    localparam logic [8:0] MAX_LENGTH_RESET = 9'd256;

    localparam logic [3:0] CODE_INDEX_MASK = 4'hf;

    localparam logic [7:0] SYSEX_START_BYTE = 8'hf0;
    localparam logic [7:0] SYSEX_END_BYTE   = 8'hf7;

    // opcodes
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // verdicts
    localparam logic [1:0] V_ABSORB = 2'd0;
    localparam logic [1:0] V_DROP   = 2'd1;
    localparam logic [1:0] V_PASS   = 2'd2;
    localparam logic [1:0] V_DONE   = 2'd3;

    // code index nibble
    localparam logic [3:0] CI_MISC      = 4'h0;
    localparam logic [3:0] CI_CABLE     = 4'h1;
    localparam logic [3:0] CI_COMMON2   = 4'h2;
    localparam logic [3:0] CI_COMMON3   = 4'h3;
    localparam logic [3:0] CI_SX_START  = 4'h4;
    localparam logic [3:0] CI_SX_END1   = 4'h5;
    localparam logic [3:0] CI_SX_END2   = 4'h6;
    localparam logic [3:0] CI_SX_END3   = 4'h7;
    localparam logic [3:0] CI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CI_NOTE_ON   = 4'h9;
    localparam logic [3:0] CI_POLY_KP   = 4'ha;
    localparam logic [3:0] CI_CTRL      = 4'hb;
    localparam logic [3:0] CI_PROGRAM   = 4'hc;
    localparam logic [3:0] CI_CHAN_KP   = 4'hd;
    localparam logic [3:0] CI_PITCH     = 4'he;
    localparam logic [3:0] CI_SINGLE    = 4'hf;

endpackage

`default_nettype wire

@@ sv/usb_midi_sysex_reassembler.sv @@
// USB MIDI event packet classifier and SysEx reassembly buffer.
// One transaction per cycle while o_ready is high; state update and buffer writes
// happen at acceptance. Two register stages (buffer read, output) lie before o_valid.
// Buffer is four byte-wide banks interleaved on address bits [1:0], so the up to three
// consecutive bytes of one packet land in distinct banks in a single cycle.
// Reset (synchronous, active low): no SysEx open, length 0, max_length 256; buffer not cleared.
`default_nettype none

module usb_midi_sysex_reassembler
    import usbsx_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_header,
    input  wire logic [7:0] i_byte_one,
    input  wire logic [7:0] i_byte_two,
    input  wire logic [7:0] i_byte_three,
    input  wire logic [7:0] i_read_index,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_verdict,
    output logic [7:0]      o_out_header,
    output logic [7:0]      o_out_byte_one,
    output logic [7:0]      o_out_byte_two,
    output logic [7:0]      o_out_byte_three,
    output logic [8:0]      o_message_length,
    output logic [7:0]      o_read_data
);

    localparam int LW  = $clog2(BUFFER_DEPTH + 1);
    localparam int CW  = (LW > 9) ? LW : 9;
    localparam int SW  = CW + 1;
    localparam int NB  = 4;
    localparam int BD  = (BUFFER_DEPTH + NB - 1) / NB;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

    // control state
    logic [8:0]    r_max_len;
    logic          r_app, n_app;
    logic [LW-1:0] r_len, n_len;

    // buffer banks and their read registers
    logic [7:0]     r_mem [NB][BD];
    logic [7:0]     r_bank_q [NB];
    logic [NB-1:0]  w_we;
    logic [BAW-1:0] w_addr [NB];
    logic [7:0]     w_data [NB];

    // middle stage
    logic       r_p_valid;
    logic [1:0] r_p_verdict;
    logic [7:0] r_p_hdr, r_p_b1, r_p_b2, r_p_b3;
    logic [8:0] r_p_len;
    logic       r_p_rd_ok;
    logic [1:0] r_p_sel;

    // output stage
    logic       r_o_valid;
    logic [1:0] r_o_verdict;
    logic [7:0] r_o_hdr, r_o_b1, r_o_b2, r_o_b3, r_o_rdata;
    logic [8:0] r_o_len;

    logic          accept, p_move;
    logic [3:0]    code_index;
    logic [LW-1:0] cur;
    logic [SW-1:0] cur_s, lim_s;
    logic          fit1, fit2, fit3;
    logic [1:0]    wr_cnt;
    logic [1:0]    verdict;
    logic [CW-1:0] ridx_c;
    logic          rd_ok;
    logic [BAW-1:0] rd_addr;

    assign p_move  = !r_o_valid || i_ready;
    assign o_ready = !r_p_valid || p_move;
    assign accept  = i_valid && o_ready;

    assign code_index = i_header[3:0] & CODE_INDEX_MASK;
    assign cur   = r_app ? r_len : '0;
    assign cur_s = SW'(cur);
    assign lim_s = (SW'(r_max_len) < SW'(BUFFER_DEPTH)) ? SW'(r_max_len) : SW'(BUFFER_DEPTH);
    assign fit1  = (cur_s + SW'(1)) <= lim_s;
    assign fit2  = (cur_s + SW'(2)) <= lim_s;
    assign fit3  = (cur_s + SW'(3)) <= lim_s;

    assign ridx_c  = CW'(i_read_index);
    assign rd_ok   = (i_opcode == OP_READ) && (ridx_c < CW'(r_len));
    assign rd_addr = ridx_c[BAW+1:2];

    // packet classification; every error path closes the SysEx and empties the buffer
    always_comb begin
        n_app   = r_app;
        n_len   = r_len;
        verdict = V_ABSORB;
        wr_cnt  = 2'd0;
        if (i_opcode == OP_PROCESS) begin
            case (code_index)
                CI_COMMON2, CI_COMMON3, CI_NOTE_OFF, CI_NOTE_ON, CI_POLY_KP,
                CI_CTRL, CI_PROGRAM, CI_CHAN_KP, CI_PITCH: begin
                    n_app   = 1'b0;
                    n_len   = '0;
                    verdict = V_PASS;
                end
                CI_SINGLE: begin
                    if (!r_app) begin
                        n_len   = '0;
                        verdict = V_PASS;
                    end else if (fit1) begin
                        wr_cnt = 2'd1;
                    end else begin
                        verdict = V_DROP;
                    end
                end
                CI_SX_START: begin
                    if (!fit3 || (!r_app && i_byte_one != SYSEX_START_BYTE)) begin
                        verdict = V_DROP;
                    end else begin
                        n_app  = 1'b1;
                        wr_cnt = 2'd3;
                    end
                end
                CI_SX_END1: begin
                    if (i_byte_one != SYSEX_END_BYTE || !r_app || !fit1) begin
                        verdict = V_DROP;
                    end else begin
                        wr_cnt  = 2'd1;
                        verdict = V_DONE;
                    end
                end
                CI_SX_END2: begin
                    if (i_byte_two != SYSEX_END_BYTE || !fit2
                            || (!r_app && i_byte_one != SYSEX_START_BYTE)) begin
                        verdict = V_DROP;
                    end else begin
                        wr_cnt  = 2'd2;
                        verdict = V_DONE;
                    end
                end
                CI_SX_END3: begin
                    if (i_byte_three != SYSEX_END_BYTE || !fit3
                            || (!r_app && i_byte_one != SYSEX_START_BYTE)) begin
                        verdict = V_DROP;
                    end else begin
                        wr_cnt  = 2'd3;
                        verdict = V_DONE;
                    end
                end
                default: begin
                    verdict = V_DROP;
                end
            endcase
            if (verdict == V_DROP) begin
                n_app = 1'b0;
                n_len = '0;
            end
            if (verdict == V_DONE) begin
                n_app = 1'b0;
            end
            if (wr_cnt != 2'd0) begin
                n_len = LW'(cur_s + SW'(wr_cnt));
            end
        end
    end

    // byte j of the packet goes to address cur + j, i.e. bank (cur + j) mod 4
    always_comb begin
        logic [1:0]    j;
        logic [SW-1:0] a;
        for (int b = 0; b < NB; b++) begin
            j         = 2'(b) - cur[1:0];
            a         = cur_s + SW'(j);
            w_we[b]   = accept && (j < wr_cnt);
            w_addr[b] = a[BAW+1:2];
            case (j)
                2'd0:    w_data[b] = i_byte_one;
                2'd1:    w_data[b] = i_byte_two;
                default: w_data[b] = i_byte_three;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NB; b++) begin
            if (w_we[b]) begin
                r_mem[b][w_addr[b]] <= w_data[b];
            end
            if (accept && rd_ok) begin
                r_bank_q[b] <= r_mem[b][rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LENGTH_RESET;
            r_app     <= 1'b0;
            r_len     <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (accept) begin
                r_app <= n_app;
                r_len <= n_len;
            end
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (r_p_valid && p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_verdict <= verdict;
            r_p_hdr     <= i_header;
            r_p_b1      <= (verdict == V_DONE) ? SYSEX_START_BYTE : i_byte_one;
            r_p_b2      <= i_byte_two;
            r_p_b3      <= i_byte_three;
            r_p_len     <= 9'(n_len);
            r_p_rd_ok   <= rd_ok;
            r_p_sel     <= i_read_index[1:0];
        end
        if (r_p_valid && p_move) begin
            r_o_verdict <= r_p_verdict;
            r_o_hdr     <= r_p_hdr;
            r_o_b1      <= r_p_b1;
            r_o_b2      <= r_p_b2;
            r_o_b3      <= r_p_b3;
            r_o_len     <= r_p_len;
            r_o_rdata   <= r_p_rd_ok ? r_bank_q[r_p_sel] : 8'd0;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_verdict        = r_o_verdict;
    assign o_out_header     = r_o_hdr;
    assign o_out_byte_one   = r_o_b1;
    assign o_out_byte_two   = r_o_b2;
    assign o_out_byte_three = r_o_b3;
    assign o_message_length = r_o_len;
    assign o_read_data      = r_o_rdata;

endmodule

`default_nettype wire

@@ sv/usbsx_checker.sv @@
// Port-level checks for the SysEx reassembler, bound to the top level.
`default_nettype none

module usbsx_checker
    import usbsx_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_verdict,
    input wire logic [7:0] o_out_header,
    input wire logic [7:0] o_out_byte_one,
    input wire logic [7:0] o_out_byte_two,
    input wire logic [7:0] o_out_byte_three,
    input wire logic [8:0] o_message_length,
    input wire logic [7:0] o_read_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_verdict) && $stable(o_out_header)
            && $stable(o_out_byte_one) && $stable(o_out_byte_two)
            && $stable(o_out_byte_three)
            && $stable(o_message_length) && $stable(o_read_data))
        else $error("result changed while stalled");

    // every drop empties the buffer
    a_drop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == V_DROP |-> o_message_length == 9'd0)
        else $error("dropped packet left a length");

    // pass-through messages close any SysEx
    a_pass_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == V_PASS |-> o_message_length == 9'd0)
        else $error("pass-through left a length");

    // a completed SysEx reports its start byte
    a_done_b1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == V_DONE |-> o_out_byte_one == SYSEX_START_BYTE
            && o_message_length != 9'd0)
        else $error("completed SysEx malformed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind usb_midi_sysex_reassembler usbsx_checker u_usbsx_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the USB MIDI SysEx reassembler.
`timescale 1ns / 1ps

module tb
    import usbsx_pkg::*;
();

    localparam int DEPTH = DEFAULT_BUFFER_DEPTH;

    typedef struct packed {
        logic       opcode;
        logic [7:0] header;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] ridx;
    } t_pkt;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] header;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [8:0] len;
        logic [7:0] rdata;
    } t_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_opcode = OP_PROCESS;
    logic [7:0] i_header = '0;
    logic [7:0] i_byte_one = '0;
    logic [7:0] i_byte_two = '0;
    logic [7:0] i_byte_three = '0;
    logic [7:0] i_read_index = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_verdict;
    logic [7:0] o_out_header;
    logic [7:0] o_out_byte_one;
    logic [7:0] o_out_byte_two;
    logic [7:0] o_out_byte_three;
    logic [8:0] o_message_length;
    logic [7:0] o_read_data;

    usb_midi_sysex_reassembler u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_header         (i_header),
        .i_byte_one       (i_byte_one),
        .i_byte_two       (i_byte_two),
        .i_byte_three     (i_byte_three),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_verdict        (o_verdict),
        .o_out_header     (o_out_header),
        .o_out_byte_one   (o_out_byte_one),
        .o_out_byte_two   (o_out_byte_two),
        .o_out_byte_three (o_out_byte_three),
        .o_message_length (o_message_length),
        .o_read_data      (o_read_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_pkt   pkt_q[$];
    t_reply reply_q[$];
    t_pkt   cur_pkt;
    int     n_taken = 0;
    int     n_pushed = 0;
    int     n_bad = 0;

    // shadow of the block's state
    logic       sx_open = 1'b0;
    int         sx_len = 0;
    logic [7:0] sx_buf[DEPTH];
    int         max_len = 256;

    function automatic logic steady();
        return n_taken >= 150 && n_taken < 260;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (sx_len < DEPTH) begin
            sx_buf[sx_len] = b;
            sx_len++;
        end
    endfunction

    function automatic logic [1:0] abort_sysex();
        sx_open = 1'b0;
        sx_len = 0;
        return V_DROP;
    endfunction

    function automatic t_reply classify_packet(t_pkt p);
        t_reply r;
        int     cur;
        int     lim;
        logic [1:0] v;
        r.header = p.header;
        r.b1 = p.b1;
        r.b2 = p.b2;
        r.b3 = p.b3;
        r.rdata = '0;
        lim = (max_len < DEPTH) ? max_len : DEPTH;
        // size checks see length 0 when nothing is open
        cur = sx_open ? sx_len : 0;
        if (p.opcode == OP_READ) begin
            v = V_ABSORB;
            if (p.ridx < sx_len)
                r.rdata = sx_buf[p.ridx];
        end else begin
            case (p.header & CODE_INDEX_MASK)
                CI_COMMON2, CI_COMMON3, CI_NOTE_OFF, CI_NOTE_ON, CI_POLY_KP,
                CI_CTRL, CI_PROGRAM, CI_CHAN_KP, CI_PITCH: begin
                    sx_open = 1'b0;
                    sx_len = 0;
                    v = V_PASS;
                end
                CI_SINGLE: begin
                    if (!sx_open) begin
                        sx_len = 0;
                        v = V_PASS;
                    end else if (cur + 1 > lim) begin
                        v = abort_sysex();
                    end else begin
                        store_byte(p.b1);
                        v = V_ABSORB;
                    end
                end
                CI_SX_START: begin
                    if (cur + 3 > lim) begin
                        v = abort_sysex();
                    end else if (!sx_open && p.b1 != SYSEX_START_BYTE) begin
                        sx_len = 0;
                        v = V_DROP;
                    end else begin
                        if (!sx_open)
                            sx_len = 0;
                        sx_open = 1'b1;
                        store_byte(p.b1);
                        store_byte(p.b2);
                        store_byte(p.b3);
                        v = V_ABSORB;
                    end
                end
                CI_SX_END1: begin
                    if (p.b1 != SYSEX_END_BYTE) begin
                        v = abort_sysex();
                    end else if (!sx_open) begin
                        sx_len = 0;
                        v = V_DROP;
                    end else if (cur + 1 > lim) begin
                        v = abort_sysex();
                    end else begin
                        store_byte(p.b1);
                        sx_open = 1'b0;
                        v = V_DONE;
                    end
                end
                CI_SX_END2: begin
                    if (p.b2 != SYSEX_END_BYTE || cur + 2 > lim) begin
                        v = abort_sysex();
                    end else if (!sx_open && p.b1 != SYSEX_START_BYTE) begin
                        sx_len = 0;
                        v = V_DROP;
                    end else begin
                        if (!sx_open)
                            sx_len = 0;
                        store_byte(p.b1);
                        store_byte(p.b2);
                        sx_open = 1'b0;
                        v = V_DONE;
                    end
                end
                CI_SX_END3: begin
                    if (p.b3 != SYSEX_END_BYTE || cur + 3 > lim) begin
                        v = abort_sysex();
                    end else if (!sx_open && p.b1 != SYSEX_START_BYTE) begin
                        sx_len = 0;
                        v = V_DROP;
                    end else begin
                        if (!sx_open)
                            sx_len = 0;
                        store_byte(p.b1);
                        store_byte(p.b2);
                        store_byte(p.b3);
                        sx_open = 1'b0;
                        v = V_DONE;
                    end
                end
                default: v = abort_sysex();
            endcase
            if (v == V_DONE)
                r.b1 = SYSEX_START_BYTE;
        end
        r.verdict = v;
        r.len = sx_len[8:0];
        return r;
    endfunction

    // driver: one transaction per accepted packet, random gaps
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                reply_q.push_back(classify_packet(cur_pkt));
                n_taken++;
            end
            if (!i_valid || o_ready) begin
                if (pkt_q.size() != 0 && (steady() || $urandom_range(0, 99) >= 19)) begin
                    cur_pkt = pkt_q.pop_front();
                    i_opcode     <= cur_pkt.opcode;
                    i_header     <= cur_pkt.header;
                    i_byte_one   <= cur_pkt.b1;
                    i_byte_two   <= cur_pkt.b2;
                    i_byte_three <= cur_pkt.b3;
                    i_read_index <= cur_pkt.ridx;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : mon
        t_reply e;
        if (o_valid && i_ready) begin
            if (reply_q.size() == 0) begin
                if (n_bad < 10)
                    $display("unexpected result: v=%0d hdr=%02h", o_verdict, o_out_header);
                n_bad++;
            end else begin
                e = reply_q.pop_front();
                if (o_verdict !== e.verdict || o_out_header !== e.header
                        || o_out_byte_one !== e.b1 || o_out_byte_two !== e.b2
                        || o_out_byte_three !== e.b3 || o_message_length !== e.len
                        || o_read_data !== e.rdata) begin
                    if (n_bad < 10) begin
                        $display("mismatch exp: v=%0d %02h %02h %02h %02h len=%0d rd=%02h",
                                 e.verdict, e.header, e.b1, e.b2, e.b3, e.len, e.rdata);
                        $display("         got: v=%0d %02h %02h %02h %02h len=%0d rd=%02h",
                                 o_verdict, o_out_header, o_out_byte_one, o_out_byte_two,
                                 o_out_byte_three, o_message_length, o_read_data);
                    end
                    n_bad++;
                end
            end
        end
        i_ready <= steady() || $urandom_range(0, 99) >= 19;
    end

    function automatic void add_hdr(logic [7:0] hdr, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3);
        t_pkt p;
        p.opcode = OP_PROCESS;
        p.header = hdr;
        p.b1 = b1;
        p.b2 = b2;
        p.b3 = b3;
        p.ridx = 8'($urandom);
        pkt_q.push_back(p);
        n_pushed++;
    endfunction

    function automatic void add_pkt(logic [3:0] ci, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3);
        add_hdr({4'($urandom), ci}, b1, b2, b3);
    endfunction

    function automatic void add_read(int idx);
        t_pkt p;
        p.opcode = OP_READ;
        p.header = 8'($urandom);
        p.b1 = 8'($urandom);
        p.b2 = 8'($urandom);
        p.b3 = 8'($urandom);
        p.ridx = 8'(idx);
        pkt_q.push_back(p);
        n_pushed++;
    endfunction

    function automatic logic [7:0] rnd_data();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    endfunction

    // well-formed SysEx of npk start packets, now and then broken or aborted
    task automatic gen_message(input int npk);
        int blen;
        int kind;
        add_pkt(CI_SX_START, SYSEX_START_BYTE, rnd_data(), rnd_data());
        blen = 3;
        for (int k = 1; k < npk; k++) begin
            if (npk < 20 && $urandom_range(0, 9) == 0) begin
                add_pkt(CI_SINGLE, rnd_data(), 8'($urandom), 8'($urandom));
                blen++;
            end
            add_pkt(CI_SX_START, rnd_data(), rnd_data(), rnd_data());
            blen += 3;
        end
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            add_pkt(4'($urandom_range(CI_NOTE_OFF, CI_PITCH)), 8'($urandom), rnd_data(),
                    rnd_data());
        end else if (kind == 1) begin
            add_pkt(4'($urandom_range(CI_SX_END1, CI_SX_END3)), rnd_data(), rnd_data(),
                    rnd_data());
        end else begin
            case ($urandom_range(1, 3))
                1: begin
                    add_pkt(CI_SX_END1, SYSEX_END_BYTE, 8'($urandom), 8'($urandom));
                    blen += 1;
                end
                2: begin
                    add_pkt(CI_SX_END2, rnd_data(), SYSEX_END_BYTE, 8'($urandom));
                    blen += 2;
                end
                default: begin
                    add_pkt(CI_SX_END3, rnd_data(), rnd_data(), SYSEX_END_BYTE);
                    blen += 3;
                end
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3))
                add_read($urandom_range(0, (blen < 255) ? blen : 255));
    endtask

    task automatic gen_noise();
        case ($urandom_range(0, 3))
            0: add_hdr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            1: add_read($urandom_range(0, 255));
            2: add_pkt(4'($urandom_range(CI_COMMON2, CI_COMMON3)), 8'($urandom),
                       rnd_data(), rnd_data());
            default: add_pkt(4'($urandom_range(CI_SX_START, CI_SX_END3)),
                             ($urandom_range(0, 1) == 1) ? SYSEX_START_BYTE : 8'($urandom),
                             8'($urandom), 8'($urandom));
        endcase
    endtask

    // sample away from the active edge so no race with driver or monitor
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pkt_q.size() != 0 || i_valid || reply_q.size() != 0);
    endtask

    task automatic write_max_len(input logic [8:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_len = v;
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : main
        int limits[7];
        int v;
        int start;
        int target;
        limits = '{5, 0, 511, 256, 3, 40, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets at the reset limit
        add_pkt(CI_NOTE_ON, 8'h90, 8'h3c, 8'h7f);
        add_pkt(CI_SINGLE, 8'hf8, 8'h00, 8'h00);              // single byte, nothing open
        add_pkt(CI_SX_START, SYSEX_START_BYTE, 8'h00, 8'h7f);
        add_pkt(CI_SINGLE, 8'h55, 8'hff, 8'hff);              // appended
        add_pkt(CI_SX_START, 8'h01, 8'h02, 8'h03);
        add_pkt(CI_SX_END3, 8'h10, 8'h20, SYSEX_END_BYTE);
        add_read(0);
        add_read(8);
        add_read(9);                                          // last stored byte, the end marker
        add_read(255);
        add_pkt(CI_SX_END1, SYSEX_END_BYTE, 8'h00, 8'h00);    // end with nothing open
        add_pkt(CI_SX_END2, SYSEX_START_BYTE, SYSEX_END_BYTE, 8'h00);
        add_pkt(CI_SX_END2, SYSEX_START_BYTE, 8'h00, 8'h00);  // bad end marker
        add_pkt(CI_SX_START, 8'h7e, 8'h01, 8'h02);            // bad start marker
        add_hdr(8'h00, 8'h00, 8'h00, 8'h00);                  // reserved index
        add_pkt(CI_CABLE, 8'hff, 8'hff, 8'hff);
        add_pkt(CI_SX_START, SYSEX_START_BYTE, 8'h11, 8'h22);
        add_pkt(CI_COMMON3, 8'hf2, 8'h01, 8'h02);             // aborts the open SysEx
        add_pkt(CI_SX_START, SYSEX_START_BYTE, 8'hff, 8'hff);
        add_pkt(CI_SX_END1, 8'h00, 8'h00, 8'h00);             // bad end marker
        add_pkt(CI_SX_START, SYSEX_START_BYTE, 8'h33, 8'h44);
        add_pkt(CI_SX_END1, SYSEX_END_BYTE, 8'hff, 8'hff);
        add_pkt(CI_SX_END3, SYSEX_START_BYTE, 8'hff, SYSEX_END_BYTE);
        add_hdr(8'hff, 8'hff, 8'hff, 8'hff);
        add_read(3);
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            v = (ph == 6) ? $urandom_range(0, 511) : limits[ph];
            write_max_len(9'(v));
            start = n_pushed;
            target = (v >= 256) ? 110 : 55;
            // 85 start packets fill 255 bytes: End1 lands on the limit, others overflow
            if (v >= 256)
                gen_message(85);
            while (n_pushed - start < target) begin
                if ($urandom_range(0, 3) == 0)
                    gen_noise();
                else
                    gen_message($urandom_range(1, 6));
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (n_bad == 0 && reply_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
